// ----- rtl/hex_grid_neighbor_address_core_macros.svh -----
// Assertion macros for the hex grid neighbor address core.
// Used by the checker module; no other dependencies.
`ifndef HEX_GRID_NEIGHBOR_ADDRESS_CORE_MACROS_SVH
`define HEX_GRID_NEIGHBOR_ADDRESS_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HGNA_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("hgna assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define HGNA_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("hgna assertion failed");

`endif

// ----- rtl/hgna_pkg.sv -----
// Package for the hex grid neighbor address core: sizes, codes, types and helpers.
// No dependencies.
`timescale 1ns / 1ps

package hgna_pkg;

  localparam int ROW_BITS    = 10;
  localparam int COLUMN_BITS = 10;
  localparam int LEVEL_BITS  = 4;

  localparam int IDX_W   = 24;
  localparam int CFG_W   = 11;
  localparam int LCFG_W  = 5;
  localparam int CIDX_W  = 2;
  localparam int AREA_W  = ROW_BITS + COLUMN_BITS + 1;
  localparam int DIV_W   = IDX_W + 2;
  localparam int NSTEP   = LEVEL_BITS + ROW_BITS;
  localparam int NSTG    = (NSTEP + 1) / 2;
  localparam int NDIR    = 6;

  localparam logic [CIDX_W-1:0] REG_ROWS   = 2'd0;
  localparam logic [CIDX_W-1:0] REG_COLS   = 2'd1;
  localparam logic [CIDX_W-1:0] REG_LEVELS = 2'd2;

  typedef enum logic [2:0] {
    DIR_NE     = 3'd0,
    DIR_NW     = 3'd1,
    DIR_SE     = 3'd2,
    DIR_SW     = 3'd3,
    DIR_E      = 3'd4,
    DIR_W      = 3'd5,
    OP_ALL     = 3'd6,
    OP_INVALID = 3'd7
  } hgna_op_e;

  // Word travelling through the divider pipeline.
  typedef struct packed {
    logic             valid;
    logic             ovf;
    logic [2:0]       op;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] rem;
    logic [NSTEP-1:0] quo;
  } hgna_pipe_t;

  // Direction held at each position of the all-neighbors sweep.
  function automatic hgna_op_e sweep_dir(input logic [2:0] pos);
    hgna_op_e d;
    case (pos)
      3'd0:    d = DIR_NE;
      3'd1:    d = DIR_NW;
      3'd2:    d = DIR_E;
      3'd3:    d = DIR_W;
      3'd4:    d = DIR_SE;
      3'd5:    d = DIR_SW;
      default: d = DIR_NE;
    endcase
    return d;
  endfunction

endpackage

// ----- rtl/hgna_divpipe.sv -----
// Pipelined restoring divider that splits a cell index into level, row and column.
// Depends on hgna_pkg. Two quotient bits are resolved per stage.
`timescale 1ns / 1ps

module hgna_divpipe import hgna_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  hgna_pipe_t        in_i,
  input  logic [AREA_W-1:0] area_i,
  input  logic [CFG_W-1:0]  cols_i,
  output hgna_pipe_t        out_o
);

  hgna_pipe_t stg_q [NSTG+1];
  hgna_pipe_t stg_d [NSTG+1];

  always_comb begin
    logic [DIV_W-1:0] dv;
    hgna_pipe_t       w;
    int               s;
    stg_d[0] = in_i;
    for (int g = 0; g < NSTG; g++) begin
      w = stg_q[g];
      for (int t = 0; t < 2; t++) begin
        s = 2 * g + t;
        if (s < NSTEP) begin
          if (s < LEVEL_BITS) begin
            dv = DIV_W'(area_i) << (LEVEL_BITS - 1 - s);
          end else begin
            dv = DIV_W'(cols_i) << (NSTEP - 1 - s);
          end
          if (DIV_W'(w.rem) >= dv) begin
            w.rem = w.rem - dv[IDX_W-1:0];
            w.quo = {w.quo[NSTEP-2:0], 1'b1};
          end else begin
            w.quo = {w.quo[NSTEP-2:0], 1'b0};
          end
        end
      end
      stg_d[g+1] = w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int g = 0; g <= NSTG; g++) begin
        stg_q[g].valid <= 1'b0;
      end
    end else if (en_i) begin
      for (int g = 0; g <= NSTG; g++) begin
        stg_q[g] <= stg_d[g];
      end
    end
  end

  assign out_o = stg_q[NSTG];

endmodule

// ----- rtl/hex_grid_neighbor_address_core.sv -----
// Top level of the hex grid neighbor address core (odd-r offset, pointy-top).
// Depends on hgna_pkg and hgna_divpipe.
`timescale 1ns / 1ps

// A cell index and opcode are taken at each clock edge where start_i is high
// and busy_o is low. Single-direction and invalid opcodes give one result word
// each and run at one item per cycle while busy_o is low; an all-neighbors
// opcode gives zero to six result words, one per cycle, so it occupies the
// result sequencer until it has sent them all. Each item passes through the
// divider pipeline, which resolves two quotient bits per stage, then through
// the bound checks and the result sequencer. busy_o is high while the result
// sequencer still has more than one word of an all-neighbors item to send; the
// whole pipeline holds in place during that time. Results are shown for one
// cycle with result_valid_o and cannot be held off by the receiver.
module hex_grid_neighbor_address_core import hgna_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [IDX_W-1:0]  cell_index_i,
  input  logic [2:0]        opcode_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CIDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  output logic              result_valid_o,
  output logic [IDX_W-1:0]  nbr_index_o,
  output logic              found_o,
  output logic [2:0]        neighbor_direction_o,
  output logic              last_o
);

  localparam logic [CFG_W-1:0]  RowMax = CFG_W'(1 << ROW_BITS);
  localparam logic [CFG_W-1:0]  ColMax = CFG_W'(1 << COLUMN_BITS);
  localparam logic [LCFG_W-1:0] LevMax = LCFG_W'(1 << LEVEL_BITS);

  // Configuration registers hold the sizes already clamped to their legal range,
  // and the level area is kept alongside so the pipeline never multiplies.
  logic [CFG_W-1:0]  rows_q, rows_d, cols_q, cols_d;
  logic [LCFG_W-1:0] levs_q, levs_d;
  logic [AREA_W-1:0] area_q, area_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    rows_d = rows_q;
    cols_d = cols_q;
    levs_d = levs_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_ROWS: begin
          rows_d = (cfg_data_i == '0) ? CFG_W'(1) :
                   (cfg_data_i > RowMax) ? RowMax : cfg_data_i;
        end
        REG_COLS: begin
          cols_d = (cfg_data_i == '0) ? CFG_W'(1) :
                   (cfg_data_i > ColMax) ? ColMax : cfg_data_i;
        end
        REG_LEVELS: begin
          levs_d = (cfg_data_i[LCFG_W-1:0] > LevMax) ? LevMax : cfg_data_i[LCFG_W-1:0];
        end
        default: begin
        end
      endcase
    end
    area_d = AREA_W'(rows_d) * AREA_W'(cols_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= CFG_W'(1);
      cols_q <= CFG_W'(1);
      levs_q <= LCFG_W'(1);
      area_q <= AREA_W'(1);
    end else begin
      rows_q <= rows_d;
      cols_q <= cols_d;
      levs_q <= levs_d;
      area_q <= area_d;
    end
  end

  // The pipeline advances whenever the sequencer takes a new item, that is while busy_o is low.
  logic       hold;
  logic       en;
  hgna_pipe_t div_in, div_out;

  assign en     = !hold;
  assign busy_o = hold;

  always_comb begin
    div_in.valid = start_i && !hold;
    div_in.ovf   = ({1'b0, cell_index_i} >= ((IDX_W + 1)'(area_q) << LEVEL_BITS));
    div_in.op    = opcode_i;
    div_in.idx   = cell_index_i;
    div_in.rem   = cell_index_i;
    div_in.quo   = '0;
  end

  hgna_divpipe u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .in_i   (div_in),
    .area_i (area_q),
    .cols_i (cols_q),
    .out_o  (div_out)
  );

  // Final stage: bound checks for all six directions, in sweep order.
  logic                f_valid_q, f_even_q, f_all_q, f_inv_q;
  logic [NDIR-1:0]     f_pend_q, f_exists_q;
  logic [IDX_W-1:0]    f_idx_q;
  logic                f_even_d;
  logic [NDIR-1:0]     f_pend_d, f_exists_d;

  always_comb begin
    logic [LEVEL_BITS-1:0] lvl;
    logic [ROW_BITS-1:0]   r;
    logic [CFG_W-1:0]      c;
    logic                  ok, up, dn, rt, lf;
    lvl = div_out.quo[NSTEP-1 -: LEVEL_BITS];
    r   = div_out.quo[ROW_BITS-1:0];
    c   = div_out.rem[CFG_W-1:0];
    ok  = !div_out.ovf && (LCFG_W'(lvl) < levs_q);
    up  = (r != '0);
    dn  = ((CFG_W'(r) + CFG_W'(1)) < rows_q);
    rt  = ((c + CFG_W'(1)) < cols_q);
    lf  = (c != '0);
    f_even_d = !r[0];
    // NE, NW, E, W, SE, SW
    f_exists_d[0] = ok && up && (f_even_d || rt);
    f_exists_d[1] = ok && up && (!f_even_d || lf);
    f_exists_d[2] = ok && rt;
    f_exists_d[3] = ok && lf;
    f_exists_d[4] = ok && dn && (f_even_d || rt);
    f_exists_d[5] = ok && dn && (!f_even_d || lf);
    case (hgna_op_e'(div_out.op))
      DIR_NE:     f_pend_d = 6'b000001;
      DIR_NW:     f_pend_d = 6'b000010;
      DIR_E:      f_pend_d = 6'b000100;
      DIR_W:      f_pend_d = 6'b001000;
      DIR_SE:     f_pend_d = 6'b010000;
      DIR_SW:     f_pend_d = 6'b100000;
      OP_ALL:     f_pend_d = f_exists_d;
      default:    f_pend_d = 6'b000001;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else if (en) begin
      f_valid_q <= div_out.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_pend_q   <= f_pend_d;
      f_exists_q <= f_exists_d;
      f_even_q   <= f_even_d;
      f_idx_q    <= div_out.idx;
      f_all_q    <= (hgna_op_e'(div_out.op) == OP_ALL);
      f_inv_q    <= (hgna_op_e'(div_out.op) == OP_INVALID);
    end
  end

  // Result sequencer: sends one pending direction per cycle, lowest sweep slot
  // first. It loads the next item when at most one word is left.
  logic [NDIR-1:0]  em_pend_q, em_exists_q;
  logic [IDX_W-1:0] em_idx_q;
  logic             em_even_q, em_all_q, em_inv_q;
  logic [NDIR-1:0]  rest;
  logic [2:0]       pos;
  hgna_op_e         dir;
  logic             sel_found;
  logic [IDX_W-1:0] sel_index;

  always_comb begin
    logic [NDIR-1:0]  low;
    logic [IDX_W-1:0] off;
    low  = em_pend_q & (~em_pend_q + NDIR'(1));
    rest = em_pend_q & ~low;
    hold = (rest != '0);
    pos  = 3'd0;
    for (int k = NDIR - 1; k >= 0; k--) begin
      if (low[k]) begin
        pos = 3'(k);
      end
    end
    dir = sweep_dir(pos);
    sel_found = em_all_q || (!em_inv_q && em_exists_q[pos]);
    case (dir)
      DIR_NE:  off = -IDX_W'(cols_q) + (em_even_q ? IDX_W'(0) : IDX_W'(1));
      DIR_NW:  off = -IDX_W'(cols_q) - (em_even_q ? IDX_W'(1) : IDX_W'(0));
      DIR_SE:  off =  IDX_W'(cols_q) + (em_even_q ? IDX_W'(0) : IDX_W'(1));
      DIR_SW:  off =  IDX_W'(cols_q) - (em_even_q ? IDX_W'(1) : IDX_W'(0));
      DIR_E:   off =  IDX_W'(1);
      DIR_W:   off = -IDX_W'(1);
      default: off = '0;
    endcase
    sel_index = sel_found ? (em_idx_q + off) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      em_pend_q      <= '0;
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= (em_pend_q != '0);
      if (hold) begin
        em_pend_q <= rest;
      end else begin
        em_pend_q <= f_valid_q ? f_pend_q : '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!hold) begin
      em_exists_q <= f_exists_q;
      em_idx_q    <= f_idx_q;
      em_even_q   <= f_even_q;
      em_all_q    <= f_all_q;
      em_inv_q    <= f_inv_q;
    end
    nbr_index_o          <= sel_index;
    found_o              <= sel_found;
    neighbor_direction_o <= em_inv_q ? 3'(DIR_NE) : 3'(dir);
    last_o               <= !hold;
  end

endmodule

// ----- rtl/hgna_checker.sv -----
// Port-level checker for the hex grid neighbor address core, with its bind.
// Depends on the assertion macro header.
`timescale 1ns / 1ps
`include "hex_grid_neighbor_address_core_macros.svh"

module hgna_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        busy_o,
  input logic        result_valid_o,
  input logic [23:0] nbr_index_o,
  input logic        found_o,
  input logic [2:0]  neighbor_direction_o,
  input logic        last_o
);

  // While busy, the sweep is still sending, so a word follows next cycle.
  `HGNA_ASSERT_NXT(a_busy_sends, clk_i, rst_ni, busy_o, result_valid_o)
  // A sweep that is not finished keeps sending without gaps.
  `HGNA_ASSERT_NXT(a_sweep_contig, clk_i, rst_ni, result_valid_o && !last_o, result_valid_o)
  // A miss always ends its item and carries a zero index.
  `HGNA_ASSERT_IMP(a_miss_shape, clk_i, rst_ni, result_valid_o && !found_o,
                   last_o && (nbr_index_o == 24'd0))
  // Directions stay within the six hexagon directions.
  `HGNA_ASSERT_IMP(a_dir_range, clk_i, rst_ni, result_valid_o,
                   neighbor_direction_o <= 3'd5)

endmodule

bind hex_grid_neighbor_address_core hgna_checker u_hgna_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .busy_o               (busy_o),
  .result_valid_o       (result_valid_o),
  .nbr_index_o          (nbr_index_o),
  .found_o              (found_o),
  .neighbor_direction_o (neighbor_direction_o),
  .last_o               (last_o)
);
